// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the interpolator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked by clk, masked while rst_n is low.
`define BTI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked by clk, also checked during reset.
`define BTI_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BTI_ASSERT(lbl, prop, msg)
`define BTI_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== hw/rtl/bti_pkg.sv =====
// ----------------------------------------------------------------------------
// bti_pkg
// Types, sizes and helpers shared by the interpolator modules.
// ----------------------------------------------------------------------------
package bti_pkg;

  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int SEG_N      = MAX_POINTS - 1;
  localparam int MIN_POINTS = 2;
  localparam int DIV_STEPS  = 16;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_QUERY = 1'b1
  } req_t;

  typedef enum logic {
    CFG_MODE  = 1'b0,
    CFG_COUNT = 1'b1
  } cfg_idx_t;

  // Segment chosen for one query; direct means dval is already the answer.
  typedef struct packed {
    logic        direct;
    logic [15:0] dval;
    logic        status;
    logic [16:0] x0;
    logic [16:0] x1;
    logic [16:0] y0;
    logic [16:0] y1;
    logic [16:0] q;
  } sel_t;

  // Sideband that rides alongside the divider.
  typedef struct packed {
    logic        direct;
    logic [15:0] dval;
    logic        status;
    logic        neg;
    logic [16:0] y0;
  } meta_t;

  // Extend a 16-bit pattern to a 17-bit two's complement value per mode.
  function automatic logic [16:0] as_val(input logic [15:0] b, input logic sgn);
    return {sgn & b[15], b};
  endfunction

endpackage

// ===== hw/rtl/bti_table.sv =====
// ----------------------------------------------------------------------------
// bti_table
// Breakpoint storage and parallel segment search for one query.
// ----------------------------------------------------------------------------
module bti_table
  import bti_pkg::*;
(
  input  logic        clk,
  input  logic        wr_en,
  input  logic [3:0]  wr_idx,
  input  logic [15:0] wr_x,
  input  logic [15:0] wr_y,
  input  logic        signed_mode,
  input  logic [4:0]  point_count,
  input  logic [15:0] query_x,
  output sel_t        sel
);

  logic [15:0]      bx_r [MAX_POINTS];
  logic [15:0]      by_r [MAX_POINTS];
  logic [CNT_W-1:0] cnt;
  logic [IDX_W-1:0] last;
  logic [16:0]      q;
  logic             lt0;
  logic             gtl;
  logic [SEG_N-1:0] hit;
  logic [SEG_N-1:0] oh;
  logic [16:0]      x0, x1, y0, y1;

  // Drop writes beyond the table.
  always_ff @(posedge clk) begin
    if (wr_en && (32'(wr_idx) < MAX_POINTS)) begin
      bx_r[IDX_W'(wr_idx)] <= wr_x;
      by_r[IDX_W'(wr_idx)] <= wr_y;
    end
  end

  assign cnt  = (32'(point_count) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : CNT_W'(point_count);
  assign last = IDX_W'(cnt - CNT_W'(1));
  assign q    = as_val(query_x, signed_mode);
  assign lt0  = $signed(q) < $signed(as_val(bx_r[0], signed_mode));
  assign gtl  = $signed(q) > $signed(as_val(bx_r[last], signed_mode));

  always_comb begin
    for (int i = 0; i < SEG_N; i++) begin
      hit[i] = (32'(i) + 1 < 32'(cnt)) &&
               ($signed(as_val(bx_r[i], signed_mode)) <= $signed(q)) &&
               ($signed(q) <= $signed(as_val(bx_r[i+1], signed_mode)));
    end
  end

  // Keep the first segment that contains the query.
  assign oh = hit & (~hit + SEG_N'(1));

  always_comb begin
    x0 = '0;
    x1 = '0;
    y0 = '0;
    y1 = '0;
    for (int i = 0; i < SEG_N; i++) begin
      x0 = x0 | ({17{oh[i]}} & as_val(bx_r[i],   signed_mode));
      x1 = x1 | ({17{oh[i]}} & as_val(bx_r[i+1], signed_mode));
      y0 = y0 | ({17{oh[i]}} & as_val(by_r[i],   signed_mode));
      y1 = y1 | ({17{oh[i]}} & as_val(by_r[i+1], signed_mode));
    end
  end

  always_comb begin
    sel.x0     = x0;
    sel.x1     = x1;
    sel.y0     = y0;
    sel.y1     = y1;
    sel.q      = q;
    sel.status = 1'b0;
    sel.direct = 1'b1;
    sel.dval   = '0;
    if (32'(cnt) < MIN_POINTS) begin
      sel.status = 1'b1;
    end else if (lt0) begin
      sel.dval = by_r[0];
    end else if (gtl) begin
      sel.dval = by_r[last];
    end else if (hit != '0) begin
      sel.direct = 1'b0;
    end
  end

endmodule

// ===== hw/rtl/bti_div.sv =====
// ----------------------------------------------------------------------------
// bti_div
// Pipelined restoring divider, one quotient bit per stage, 32/16 -> 16.
// ----------------------------------------------------------------------------
module bti_div
  import bti_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_v,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  input  meta_t       in_meta,
  output logic        out_v,
  output logic [15:0] quo,
  output logic        rem_nz,
  output meta_t       out_meta
);

  typedef struct packed {
    logic [15:0] rem;
    logic [15:0] dvd;
    logic [15:0] quo;
    logic [15:0] dsr;
    meta_t       meta;
  } dstage_t;

  dstage_t              st_in;
  dstage_t              st_r [DIV_STEPS];
  logic [DIV_STEPS-1:0] v_r;

  function automatic dstage_t div_step(input dstage_t s);
    dstage_t     o;
    logic [16:0] t;
    o = s;
    t = {s.rem, s.dvd[15]};
    o.dvd = {s.dvd[14:0], 1'b0};
    if (t >= {1'b0, s.dsr}) begin
      o.rem = 16'(t - {1'b0, s.dsr});
      o.quo = {s.quo[14:0], 1'b1};
    end else begin
      o.rem = t[15:0];
      o.quo = {s.quo[14:0], 1'b0};
    end
    return o;
  endfunction

  assign st_in.rem  = dividend[31:16];
  assign st_in.dvd  = dividend[15:0];
  assign st_in.quo  = '0;
  assign st_in.dsr  = divisor;
  assign st_in.meta = in_meta;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          st_r[k] <= div_step(st_in);
        end
      end
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (en) begin
          v_r[k] <= in_v;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) begin
          st_r[k] <= div_step(st_r[k-1]);
        end
      end
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (en) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign out_v    = v_r[DIV_STEPS-1];
  assign quo      = st_r[DIV_STEPS-1].quo;
  assign rem_nz   = st_r[DIV_STEPS-1].rem != '0;
  assign out_meta = st_r[DIV_STEPS-1].meta;

endmodule

// ===== hw/rtl/breakpoint_table_interpolator.sv =====
// ----------------------------------------------------------------------------
// breakpoint_table_interpolator
// Piecewise linear lookup over a 16-entry breakpoint table.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in_     | input     | in_valid / in_ready   | req_type, point_index, point_x,
//          |           |                       | point_y, query_x
//  out_    | output    | out_valid / out_ready | out_y, out_status
//  cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  One request enters per cycle unless the pipeline holds; a query passes
//  search, difference, multiply, magnitude, 16 divider stages and the
//  result stage. The 16-stage restoring divider sets the latency.
//  Table writes take effect at acceptance and produce no result.
//  The whole pipeline holds while a result waits and out_ready is low.
//  Synchronous active-low reset clears valid bits and the mode and count
//  registers; table contents stay undefined until written.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module breakpoint_table_interpolator
  import bti_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [3:0]  in_point_index,
  input  logic [15:0] in_point_x,
  input  logic [15:0] in_point_y,
  input  logic [15:0] in_query_x,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_y,
  output logic        out_status,
  // register write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  // Registers.
  logic        mode_r;
  logic [4:0]  count_r;

  // Pipeline control: everything advances together unless the result stalls.
  logic        adv;
  logic        acc;

  // Stage 1: selected segment.
  sel_t        sel;
  sel_t        s1_r;
  logic        s1_v_r;

  // Stage 2: differences.
  logic        s2_v_r;
  logic        s2_direct_r;
  logic [15:0] s2_dval_r;
  logic        s2_status_r;
  logic [16:0] s2_y0_r;
  logic [15:0] s2_dx_r;
  logic [15:0] s2_dq_r;
  logic [16:0] s2_dy_r;
  logic [16:0] dx_full;
  logic [16:0] dq_full;

  // Stage 3: product.
  logic               s3_v_r;
  meta_t              s3_meta_r;
  logic [15:0]        s3_dx_r;
  logic signed [33:0] s3_p_r;

  // Stage 4: magnitude for the divider.
  logic        s4_v_r;
  meta_t       s4_meta_r;
  logic [15:0] s4_dx_r;
  logic [31:0] s4_mag_r;
  meta_t       s3_meta_nxt;
  meta_t       s4_meta_nxt;
  logic [33:0] p_abs;

  // Divider output.
  logic        div_v;
  logic [15:0] div_quo;
  logic        div_rem_nz;
  meta_t       div_meta;

  // Result stage.
  logic        out_valid_r;
  logic [15:0] out_y_r;
  logic        out_status_r;
  logic [17:0] qx;
  logic [17:0] adj;
  logic [17:0] fl;
  logic [17:0] res;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign acc       = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      count_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MODE:  mode_r  <= cfg_data[0];
        CFG_COUNT: count_r <= cfg_data;
        default:   ;
      endcase
    end
  end

  // Table and segment search on the incoming request.
  bti_table u_table (
    .clk         (clk),
    .wr_en       (acc && (req_t'(in_req_type) == REQ_WRITE)),
    .wr_idx      (in_point_index),
    .wr_x        (in_point_x),
    .wr_y        (in_point_y),
    .signed_mode (mode_r),
    .point_count (count_r),
    .query_x     (in_query_x),
    .sel         (sel)
  );

  // Valid bits travel with the data; only queries become valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= acc && (req_t'(in_req_type) == REQ_QUERY);
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  // Both differences are non-negative inside a found segment.
  assign dx_full = s1_r.x1 - s1_r.x0;
  assign dq_full = s1_r.q - s1_r.x0;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r        <= sel;
      // A zero-width segment answers with its first y.
      s2_direct_r <= s1_r.direct || (dx_full == '0);
      s2_dval_r   <= s1_r.direct ? s1_r.dval : s1_r.y0[15:0];
      s2_status_r <= s1_r.status;
      s2_y0_r     <= s1_r.y0;
      s2_dx_r     <= dx_full[15:0];
      s2_dq_r     <= dq_full[15:0];
      s2_dy_r     <= s1_r.y1 - s1_r.y0;
      s3_meta_r   <= s3_meta_nxt;
      s3_dx_r     <= s2_dx_r;
      s3_p_r      <= $signed(s2_dy_r) * $signed({1'b0, s2_dq_r});
      s4_meta_r   <= s4_meta_nxt;
      s4_dx_r     <= s3_dx_r;
      s4_mag_r    <= p_abs[31:0];
    end
  end

  always_comb begin
    s3_meta_nxt.direct = s2_direct_r;
    s3_meta_nxt.dval   = s2_dval_r;
    s3_meta_nxt.status = s2_status_r;
    s3_meta_nxt.neg    = 1'b0;
    s3_meta_nxt.y0     = s2_y0_r;
  end

  // Carry the product sign beside the magnitude.
  always_comb begin
    s4_meta_nxt     = s3_meta_r;
    s4_meta_nxt.neg = s3_p_r[33];
  end

  assign p_abs = s3_p_r[33] ? 34'(-s3_p_r) : 34'(s3_p_r);

  // |dy*dq| / dx; the quotient never exceeds |dy|.
  bti_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_v     (s4_v_r),
    .dividend (s4_mag_r),
    .divisor  (s4_dx_r),
    .in_meta  (s4_meta_r),
    .out_v    (div_v),
    .quo      (div_quo),
    .rem_nz   (div_rem_nz),
    .out_meta (div_meta)
  );

  // Floor of y0 + p/dx, then truncate toward zero. The result stays between
  // the two segment ends, so no saturation is reachable here.
  assign qx  = {2'b00, div_quo};
  assign adj = div_meta.neg ? (18'(0) - qx - 18'(div_rem_nz)) : qx;
  assign fl  = {div_meta.y0[16], div_meta.y0} + adj;
  assign res = fl + 18'(fl[17] & div_rem_nz);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= div_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_y_r      <= div_meta.direct ? div_meta.dval : res[15:0];
      out_status_r <= div_meta.status;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_y      = out_y_r;
  assign out_status = out_status_r;

  `BTI_ASSERT_RST(a_reset_clears, !rst_n |=> !out_valid, "result valid after reset")
  `BTI_ASSERT(a_query_enters, (acc && in_req_type) |=> s1_v_r, "query lost at entry")
  `BTI_ASSERT(a_write_silent, (acc && !in_req_type) |=> !s1_v_r, "write made a result")
  `BTI_ASSERT(a_stall_holds, !adv |=> ($stable(div_v) && $stable(s4_v_r)), "stall moved pipe")
  `BTI_ASSERT(a_status_zero, (out_valid && out_status) |-> (out_y == '0), "status result nonzero")

endmodule
